FILE: design/mqe_pkg.sv
// mqe_pkg: constants, probability tables, types and the byte-out function of the mq encoder
// used by mqe_ctx_mem, mqe_byte_out and mq_arithmetic_encoder_core; depends on nothing
package mqe_pkg;

  localparam int NUM_CONTEXTS = 19;
  localparam int CTX_AW       = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
  localparam int QE_N         = 47;
  localparam int MAX_OUT      = 3;
  localparam int RENORM_MAX   = 16;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_FLUSH  = 1'b1;

  localparam logic [15:0] A_INIT     = 16'h8000;
  localparam logic [3:0]  CT_INIT    = 4'd12;
  localparam logic [3:0]  CT_STUFF   = 4'd7;
  localparam logic [3:0]  CT_PLAIN   = 4'd8;
  localparam logic [7:0]  STUFF_BYTE = 8'hFF;
  localparam logic [27:0] TERM_FILL  = 28'h000FFFF;
  localparam logic [27:0] TERM_HALF  = 28'h0008000;

  localparam int CTX_INIT_A = 0;
  localparam int CTX_INIT_B = 17;
  localparam int CTX_INIT_C = 18;
  localparam logic [5:0] IDX_INIT_A = 6'd4;
  localparam logic [5:0] IDX_INIT_B = 6'd3;
  localparam logic [5:0] IDX_INIT_C = 6'd46;

  localparam logic [15:0] QE_TBL [QE_N] = '{
    16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
    16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
    16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
    16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
    16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
    16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601};

  localparam logic [5:0] NMPS_TBL [QE_N] = '{
    6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12,
    6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
    6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
    6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46};

  localparam logic [5:0] NLPS_TBL [QE_N] = '{
    6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
    6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21,
    6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
    6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46};

  localparam logic SWAP_TBL [QE_N] = '{
    1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
    1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0};

  // state word: table index in [6:1], mps in [0]
  typedef logic [6:0] mqe_cst_t;
  typedef logic [CTX_AW-1:0] mqe_addr_t;

  typedef struct packed {
    logic      we;
    mqe_addr_t addr;
    mqe_cst_t  data;
  } mqe_ctx_wr_t;

  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       fin;
    logic       last_flag;
  } mqe_emit_t;

  typedef struct packed {
    logic ok;
    logic hold_v;
  } mqe_ost_t;

  typedef struct packed {
    logic [27:0] c;
    logic [3:0]  ct;
    logic [7:0]  pb;
    logic        emit;
    logic [7:0]  eb;
  } mqe_put_t;

  function automatic mqe_cst_t ctx_init(mqe_addr_t a);
    mqe_cst_t r;
    r = '0;
    if (NUM_CONTEXTS > CTX_INIT_A && a == CTX_AW'(CTX_INIT_A)) r = {IDX_INIT_A, 1'b0};
    if (NUM_CONTEXTS > CTX_INIT_B && a == CTX_AW'(CTX_INIT_B)) r = {IDX_INIT_B, 1'b0};
    if (NUM_CONTEXTS > CTX_INIT_C && a == CTX_AW'(CTX_INIT_C)) r = {IDX_INIT_C, 1'b0};
    return r;
  endfunction

  // byte out with carry into the pending byte and stuffing after 0xff
  function automatic mqe_put_t put_out(logic [27:0] c, logic [7:0] pb, logic pv);
    mqe_put_t    r;
    logic [7:0]  pb1;
    logic [27:0] c1;
    logic        stuff;
    pb1   = pb;
    c1    = c;
    stuff = 1'b0;
    if (!pv || pb != STUFF_BYTE) begin
      if (c[27] && pv) begin
        pb1   = pb + 8'd1;
        stuff = (pb1 == STUFF_BYTE);
      end
      if (stuff) c1[27] = 1'b0;
    end else begin
      stuff = 1'b1;
    end
    if (stuff) begin
      r.pb = c1[27:20];
      r.c  = {8'b0, c1[19:0]};
      r.ct = CT_STUFF;
    end else begin
      r.pb = c1[26:19];
      r.c  = {9'b0, c1[18:0]};
      r.ct = CT_PLAIN;
    end
    r.emit = pv;
    r.eb   = pb1;
    return r;
  endfunction

endpackage

FILE: design/mqe_ctx_mem.sv
// mqe_ctx_mem: per-context probability state memory, one read and one write port
// synchronous read; entries never written read as the initial states; uses mqe_pkg
module mqe_ctx_mem (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rd_en,
  input  mqe_pkg::mqe_addr_t  rd_addr,
  output mqe_pkg::mqe_cst_t   rd_data,
  input  mqe_pkg::mqe_ctx_wr_t wr
);

  mqe_pkg::mqe_cst_t  mem [mqe_pkg::NUM_CONTEXTS];
  logic [mqe_pkg::NUM_CONTEXTS-1:0] vld_r;
  mqe_pkg::mqe_cst_t  rdata_r;
  mqe_pkg::mqe_addr_t raddr_r;
  logic               rvld_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      raddr_r <= rd_addr;
      if (wr.we && wr.addr == rd_addr) begin
        rdata_r <= wr.data;
      end else begin
        rdata_r <= mem[rd_addr];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (wr.we) begin
        vld_r[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        rvld_r <= vld_r[rd_addr] || (wr.we && wr.addr == rd_addr);
      end
    end
  end

  assign rd_data = rvld_r ? rdata_r : mqe_pkg::ctx_init(raddr_r);

endmodule

FILE: design/mqe_byte_out.sv
// mqe_byte_out: one-byte hold stage and output register of the coded byte stream
// the held byte learns its last flag at the end of a request; uses mqe_pkg
module mqe_byte_out (
  input  logic               clk,
  input  logic               rst_n,
  input  mqe_pkg::mqe_emit_t emit,
  output mqe_pkg::mqe_ost_t  ost,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,   // out_byte
  output logic               out_tlast    // last
);

  logic       hold_v_r, hold_v_nxt;
  logic [7:0] hold_r, hold_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       ol_r, ol_nxt;
  logic       ok;

  assign ok = !hold_v_r || !ov_r || out_tready;

  always_comb begin
    hold_v_nxt = hold_v_r;
    hold_nxt   = hold_r;
    ov_nxt     = ov_r && !out_tready;
    ob_nxt     = ob_r;
    ol_nxt     = ol_r;
    if (emit.push && ok) begin
      if (hold_v_r) begin
        ov_nxt = 1'b1;
        ob_nxt = hold_r;
        ol_nxt = 1'b0;
      end
      hold_nxt   = emit.data;
      hold_v_nxt = 1'b1;
    end else if (emit.fin && ok) begin
      if (hold_v_r) begin
        ov_nxt = 1'b1;
        ob_nxt = hold_r;
        ol_nxt = emit.last_flag;
      end
      hold_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      ov_r     <= 1'b0;
    end else begin
      hold_v_r <= hold_v_nxt;
      ov_r     <= ov_nxt;
    end
    hold_r <= hold_nxt;
    ob_r   <= ob_nxt;
    ol_r   <= ol_nxt;
  end

  assign ost.ok     = ok;
  assign ost.hold_v = hold_v_r;
  assign out_tvalid = ov_r;
  assign out_tdata  = ob_r;
  assign out_tlast  = ol_r;

endmodule

FILE: design/mq_arithmetic_encoder_core.sv
// mq_arithmetic_encoder_core: mq arithmetic encoder with context memory and byte output stage
// encode: k renormalization shifts (0..16), one shift per cycle unless the output stalls
// flush: FL_TOP, FL_PUT0/1, FL_END, DONE; one request at a time; last byte leaves after done
// context state read is registered (synchronous memory) before the interval update
// reset: synchronous active low; coder registers to initial values, context valid bits cleared
// so every context reads its standard initial state until written, no clearing pass
module mq_arithmetic_encoder_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // bit_req, context_req[4:0], zero fill
  input  logic       in_tuser,   // mode
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // out_byte
  output logic       out_tlast
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_CALC    = 8'b0000_0010,
    S_RENORM  = 8'b0000_0100,
    S_FL_TOP  = 8'b0000_1000,
    S_FL_PUT0 = 8'b0001_0000,
    S_FL_PUT1 = 8'b0010_0000,
    S_FL_END  = 8'b0100_0000,
    S_DONE    = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [15:0]        a_r, a_nxt;
  logic [27:0]        c_r, c_nxt;
  logic [3:0]         ct_r, ct_nxt;
  logic [7:0]         pb_r, pb_nxt;
  logic               pv_r, pv_nxt;
  logic [1:0]         cnt_r, cnt_nxt;
  logic [3:0]         n_r, n_nxt;
  logic               mode_r, mode_nxt;
  logic               bit_r, bit_nxt;
  mqe_pkg::mqe_addr_t ctx_r, ctx_nxt;

  logic               in_acc;
  logic [4:0]         ctx_in;
  logic               ctx_ok;
  logic               rd_en;
  mqe_pkg::mqe_addr_t rd_addr;
  mqe_pkg::mqe_cst_t  st;
  mqe_pkg::mqe_ctx_wr_t wr;
  mqe_pkg::mqe_emit_t emit;
  mqe_pkg::mqe_ost_t  ost;

  logic [5:0]  idx;
  logic        mps;
  logic [15:0] qe;
  logic [15:0] a_sub;
  logic [27:0] c_add;
  logic        a_lt;
  logic [15:0] a_sh;
  logic [27:0] c_sh;
  logic [3:0]  ct_dec;
  logic [28:0] top;
  logic [27:0] c_or;
  logic [27:0] c_term;
  logic [27:0] c_fs;
  mqe_pkg::mqe_put_t po_r, po_f;
  logic        cnt_room;
  logic        push_want;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ctx_in    = in_tdata[5:1];
  assign ctx_ok    = 32'(ctx_in) < mqe_pkg::NUM_CONTEXTS;
  assign rd_addr   = mqe_pkg::CTX_AW'(ctx_in);
  assign rd_en     = in_acc && (in_tuser == mqe_pkg::MODE_ENCODE) && ctx_ok;

  assign idx   = (st[6:1] >= 6'(mqe_pkg::QE_N)) ? st[6:1] - 6'(mqe_pkg::QE_N) : st[6:1];
  assign mps   = st[0];
  assign qe    = mqe_pkg::QE_TBL[idx];
  assign a_sub = a_r - qe;
  assign c_add = c_r + {12'b0, qe};
  assign a_lt  = a_sub < qe;

  assign a_sh   = {a_r[14:0], 1'b0};
  assign c_sh   = {c_r[26:0], 1'b0};
  assign ct_dec = (ct_r != 4'd0) ? ct_r - 4'd1 : ct_r;
  assign po_r   = mqe_pkg::put_out(c_sh, pb_r, pv_r);

  assign top    = {1'b0, c_r} + {13'b0, a_r};
  assign c_or   = c_r | mqe_pkg::TERM_FILL;
  assign c_term = ({1'b0, c_or} >= top) ? c_or - mqe_pkg::TERM_HALF : c_or;
  assign c_fs   = c_r << ct_r;
  assign po_f   = mqe_pkg::put_out(c_fs, pb_r, pv_r);

  assign cnt_room = 32'(cnt_r) < mqe_pkg::MAX_OUT;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    c_nxt     = c_r;
    ct_nxt    = ct_r;
    pb_nxt    = pb_r;
    pv_nxt    = pv_r;
    cnt_nxt   = cnt_r;
    n_nxt     = n_r;
    mode_nxt  = mode_r;
    bit_nxt   = bit_r;
    ctx_nxt   = ctx_r;
    wr.we     = 1'b0;
    wr.addr   = ctx_r;
    wr.data   = '0;
    emit      = '0;
    push_want = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_tuser;
          bit_nxt  = in_tdata[0];
          ctx_nxt  = rd_addr;
          cnt_nxt  = 2'd0;
          if (in_tuser == mqe_pkg::MODE_FLUSH) begin
            state_nxt = S_FL_TOP;
          end else if (ctx_ok) begin
            state_nxt = S_CALC;
          end
        end
      end
      S_CALC: begin
        n_nxt = 4'd0;
        if (bit_r == mps) begin
          if (a_sub[15]) begin
            a_nxt     = a_sub;
            c_nxt     = c_add;
            state_nxt = S_DONE;
          end else begin
            if (a_lt) begin
              a_nxt = qe;
            end else begin
              a_nxt = a_sub;
              c_nxt = c_add;
            end
            wr.we     = 1'b1;
            wr.data   = {mqe_pkg::NMPS_TBL[idx], mps};
            state_nxt = S_RENORM;
          end
        end else begin
          if (a_lt) begin
            a_nxt = a_sub;
            c_nxt = c_add;
          end else begin
            a_nxt = qe;
          end
          wr.we     = 1'b1;
          wr.data   = {mqe_pkg::NLPS_TBL[idx], mps ^ mqe_pkg::SWAP_TBL[idx]};
          state_nxt = S_RENORM;
        end
      end
      S_RENORM: begin
        push_want = (ct_dec == 4'd0) && po_r.emit && cnt_room;
        if (!push_want || ost.ok) begin
          a_nxt  = a_sh;
          c_nxt  = c_sh;
          ct_nxt = ct_dec;
          if (ct_dec == 4'd0) begin
            c_nxt  = po_r.c;
            ct_nxt = po_r.ct;
            pb_nxt = po_r.pb;
            pv_nxt = 1'b1;
          end
          if (push_want) begin
            emit.push = 1'b1;
            emit.data = po_r.eb;
            cnt_nxt   = cnt_r + 2'd1;
          end
          n_nxt = n_r + 4'd1;
          if (a_sh[15] || n_r == 4'(mqe_pkg::RENORM_MAX - 1)) begin
            state_nxt = S_DONE;
          end
        end
      end
      S_FL_TOP: begin
        c_nxt     = c_term;
        state_nxt = S_FL_PUT0;
      end
      S_FL_PUT0, S_FL_PUT1: begin
        push_want = po_f.emit && cnt_room;
        if (!push_want || ost.ok) begin
          c_nxt  = po_f.c;
          ct_nxt = po_f.ct;
          pb_nxt = po_f.pb;
          pv_nxt = 1'b1;
          if (push_want) begin
            emit.push = 1'b1;
            emit.data = po_f.eb;
            cnt_nxt   = cnt_r + 2'd1;
          end
          state_nxt = (state_r == S_FL_PUT0) ? S_FL_PUT1 : S_FL_END;
        end
      end
      S_FL_END: begin
        push_want = pv_r && (pb_r != mqe_pkg::STUFF_BYTE) && cnt_room;
        if (!push_want || ost.ok) begin
          if (push_want) begin
            emit.push = 1'b1;
            emit.data = pb_r;
            cnt_nxt   = cnt_r + 2'd1;
          end
          a_nxt     = mqe_pkg::A_INIT;
          c_nxt     = '0;
          ct_nxt    = mqe_pkg::CT_INIT;
          pb_nxt    = '0;
          pv_nxt    = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        emit.fin       = 1'b1;
        emit.last_flag = (mode_r == mqe_pkg::MODE_FLUSH);
        if (ost.ok) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      a_r     <= mqe_pkg::A_INIT;
      c_r     <= '0;
      ct_r    <= mqe_pkg::CT_INIT;
      pb_r    <= '0;
      pv_r    <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      a_r     <= a_nxt;
      c_r     <= c_nxt;
      ct_r    <= ct_nxt;
      pb_r    <= pb_nxt;
      pv_r    <= pv_nxt;
      cnt_r   <= cnt_nxt;
    end
    n_r    <= n_nxt;
    mode_r <= mode_nxt;
    bit_r  <= bit_nxt;
    ctx_r  <= ctx_nxt;
  end

  mqe_ctx_mem u_ctx_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (st),
    .wr      (wr)
  );

  mqe_byte_out u_byte_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit       (emit),
    .ost        (ost),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

`ifndef SYNTH
  a_idle_hold_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !ost.hold_v)
    else $error("held byte left over at idle");

  a_idle_interval_norm: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> a_r[15])
    else $error("interval not normalized at idle");

  a_idle_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (ct_r != 4'd0 && ct_r <= mqe_pkg::CT_INIT))
    else $error("bit counter out of range at idle");

  a_flush_resets_coder: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FL_END && state_nxt == S_DONE) |=> (!pv_r && c_r == '0))
    else $error("coder not reinitialized after flush");
`endif

endmodule
